>>> src/nlp_pkg.sv
// Shared types and constants for the next lexicographic permutation block.
// No dependencies; used by nlp_enc, nlp_permute and the top level under src.
package nlp_pkg;

  // Element slots carried by one word, and field widths on the ports
  localparam int SLOTS   = 8;
  localparam int POS_W   = 3;
  localparam int LEN_W   = 4;
  localparam int FIELD_W = 8;

  // Packed stream widths, rounded up to whole bytes
  localparam int IN_BITS  = LEN_W + SLOTS * FIELD_W;
  localparam int OUT_BITS = SLOTS * FIELD_W + 2 * POS_W + 1;
  localparam int S_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int M_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Output bit offsets
  localparam int PIV_LSB  = SLOTS * FIELD_W;
  localparam int SUCC_LSB = PIV_LSB + POS_W;
  localparam int WRAP_BIT = SUCC_LSB + POS_W;

  // Result of a rightmost-hit search across lanes
  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] pos;
  } hit_t;

endpackage

>>> src/nlp_lane.sv
// One compare lane: flags an enabled position whose element is strictly
// greater than a reference element. Depends on nothing.
module nlp_lane #(
  parameter int W = 8
) (
  input  logic         en,
  input  logic [W-1:0] lo,
  input  logic [W-1:0] hi,
  output logic         hit
);

  // Unsigned strict compare, gated by the lane's position window
  assign hit = en && (lo < hi);

endmodule

>>> src/nlp_enc.sv
// Merge stage: finds the highest lane that raised its flag.
// Depends on nlp_pkg for hit_t.
module nlp_enc #(
  parameter int N = 8
) (
  input  logic [N-1:0]  flags,
  output nlp_pkg::hit_t hit
);
  import nlp_pkg::*;

  // Later lanes override earlier ones, so the rightmost hit wins
  always_comb begin
    hit = '0;
    for (int i = 0; i < N; i++) begin
      if (flags[i]) begin
        hit.found = 1'b1;
        hit.pos   = POS_W'(i);
      end
    end
  end

endmodule

>>> src/nlp_permute.sv
// Output assembly: swaps pivot and successor and reverses the tail, or
// reverses the whole valid range when no pivot exists. Depends on nlp_pkg.
module nlp_permute #(
  parameter int W = 8
) (
  input  logic [nlp_pkg::LEN_W-1:0] len,
  input  nlp_pkg::hit_t             piv,
  input  logic [nlp_pkg::POS_W-1:0] succ,
  input  logic [W-1:0]              a [nlp_pkg::SLOTS],
  output logic [W-1:0]              y [nlp_pkg::SLOTS]
);
  import nlp_pkg::*;

  // Each output position picks its source from the input slots
  always_comb begin
    logic [LEN_W-1:0] src;
    for (int k = 0; k < SLOTS; k++) begin
      src  = '0;
      y[k] = a[k];
      if (piv.found) begin
        if (POS_W'(k) == piv.pos) begin
          y[k] = a[succ];
        end else if (POS_W'(k) > piv.pos && LEN_W'(k) < len) begin
          // reversed tail; the successor slot now holds the old pivot
          src  = LEN_W'(piv.pos) + len - LEN_W'(k);
          y[k] = (src[POS_W-1:0] == succ) ? a[piv.pos] : a[src[POS_W-1:0]];
        end
      end else if (LEN_W'(k) < len) begin
        // descending input: mirror the valid range into ascending order
        src  = len - LEN_W'(1) - LEN_W'(k);
        y[k] = a[src[POS_W-1:0]];
      end
    end
  end

endmodule

>>> src/next_lexicographic_permutation_top.sv
// Top level of the next lexicographic permutation block: stream ports and a
// three-stage pipeline. Depends on nlp_pkg, nlp_lane, nlp_enc, nlp_permute.
//
//  channel  dir  fields (lowest bit up)
//  s_axis   in   length[3:0], elem_0..elem_7 (8 b each), zero pad to 72
//  m_axis   out  out_0..out_7 (8 b each), pivot_pos[2:0], succ_pos[2:0],
//                wrapped, zero pad to 72
//
// One word per cycle sustained while the output is ready; each word passes
// through ascent lanes and pivot search, successor lanes and search, then output
// assembly into the output register. Each stage advances when it is empty
// or the stage after it moves, so bubbles close up under a stalled output.
// rst clears the stage valid flags only; no other state.
module next_lexicographic_permutation_top #(
  parameter int MAX_LEN   = 8,
  parameter int ELEM_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // length, elem_0 .. elem_7, pad
  input  logic [nlp_pkg::S_DATA_W-1:0] s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // out_0 .. out_7, pivot_pos, succ_pos, wrapped, pad
  output logic [nlp_pkg::M_DATA_W-1:0] m_axis_tdata
);
  import nlp_pkg::*;

  // Elements keep only the low bits that fit both the field and ELEM_BITS
  localparam int EW = (ELEM_BITS > FIELD_W) ? FIELD_W : ELEM_BITS;

  // Pipeline registers
  logic             v1, v2, v3;
  logic [LEN_W-1:0] len1, len2;
  logic [EW-1:0]    a1 [SLOTS];
  logic [EW-1:0]    a2 [SLOTS];
  hit_t             piv1, piv2;
  logic [EW-1:0]    pval1;
  logic [POS_W-1:0] succ2;
  logic [M_DATA_W-1:0] out_word;

  // Stage handshake
  logic rdy1, rdy2, rdy3;
  assign rdy3 = !v3 || m_axis_tready;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign s_axis_tready = rdy1;

  // Input unpack, element masking, length saturation
  logic [LEN_W-1:0] len_in, len_sat;
  logic [EW-1:0]    a_in [SLOTS];
  assign len_in  = s_axis_tdata[LEN_W-1:0];
  assign len_sat = (len_in > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : len_in;

  // Stage 1 lanes: ascent between neighbors inside the valid range
  logic [SLOTS-2:0] ascent;
  hit_t             piv_in;

  for (genvar i = 0; i < SLOTS; i++) begin : g_unpack
    assign a_in[i] = s_axis_tdata[LEN_W + i*FIELD_W +: EW];
  end

  for (genvar i = 0; i < SLOTS - 1; i++) begin : g_asc
    nlp_lane #(.W(EW)) u_lane (
      .en  (LEN_W'(i + 1) < len_sat),
      .lo  (a_in[i]),
      .hi  (a_in[i+1]),
      .hit (ascent[i])
    );
  end

  nlp_enc #(.N(SLOTS - 1)) u_piv_enc (
    .flags (ascent),
    .hit   (piv_in)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= s_axis_tvalid;
    end
    if (rdy1 && s_axis_tvalid) begin
      len1  <= len_sat;
      a1    <= a_in;
      piv1  <= piv_in;
      pval1 <= a_in[piv_in.pos];
    end
  end

  // Stage 2 lanes: elements right of the pivot that exceed it
  logic [SLOTS-1:0] greater;
  hit_t             succ_hit;

  for (genvar j = 0; j < SLOTS; j++) begin : g_gt
    nlp_lane #(.W(EW)) u_lane (
      .en  (piv1.found && (POS_W'(j) > piv1.pos) && (LEN_W'(j) < len1)),
      .lo  (pval1),
      .hi  (a1[j]),
      .hit (greater[j])
    );
  end

  nlp_enc #(.N(SLOTS)) u_succ_enc (
    .flags (greater),
    .hit   (succ_hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
    if (rdy2 && v1) begin
      len2  <= len1;
      a2    <= a1;
      piv2  <= piv1;
      succ2 <= succ_hit.pos;
    end
  end

  // Stage 3: swap and reverse, pack into the output register
  logic [EW-1:0]       y [SLOTS];
  logic [M_DATA_W-1:0] out_next;

  nlp_permute #(.W(EW)) u_perm (
    .len  (len2),
    .piv  (piv2),
    .succ (succ2),
    .a    (a2),
    .y    (y)
  );

  always_comb begin
    out_next = '0;
    for (int k = 0; k < SLOTS; k++) begin
      out_next[k*FIELD_W +: FIELD_W] = FIELD_W'(y[k]);
    end
    out_next[PIV_LSB  +: POS_W] = piv2.found ? piv2.pos : '0;
    out_next[SUCC_LSB +: POS_W] = piv2.found ? succ2 : '0;
    out_next[WRAP_BIT]          = !piv2.found;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
    if (rdy3 && v2) begin
      out_word <= out_next;
    end
  end

  assign m_axis_tvalid = v3;
  assign m_axis_tdata  = out_word;

  // A wrapped word reports both positions as zero
  a_wrap_pos: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[WRAP_BIT] |->
      m_axis_tdata[PIV_LSB +: POS_W] == '0 && m_axis_tdata[SUCC_LSB +: POS_W] == '0)
    else $error("wrapped word with nonzero positions");

  // Otherwise the successor lies right of the pivot
  a_succ_right: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[WRAP_BIT] |->
      m_axis_tdata[SUCC_LSB +: POS_W] > m_axis_tdata[PIV_LSB +: POS_W])
    else $error("successor not right of pivot");

  // Input is held off only when every stage is occupied
  a_full_pipe: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> v1 && v2 && v3)
    else $error("input stalled with a free stage");

  // An accepted word lands in stage 1
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> v1)
    else $error("accepted word lost at stage 1");

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for next_lexicographic_permutation_top: stream
// stimulus, a scoreboard that predicts the next arrangement, random handshakes.
// Depends on nlp_pkg and the block's RTL under src.
`timescale 1ns / 100ps

module tb_top;
  import nlp_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 500;

  // One arrangement as sent, and the successor the block should return
  typedef struct packed {
    logic [LEN_W-1:0]                length;
    logic [SLOTS-1:0][FIELD_W-1:0]   elem;
  } arrangement_t;

  typedef struct packed {
    logic [SLOTS-1:0][FIELD_W-1:0]   elem;
    logic [POS_W-1:0]                pivot;
    logic [POS_W-1:0]                succ;
    logic                            wrapped;
  } successor_t;

  typedef enum int {GEN_WIDE, GEN_DUP, GEN_FALLING, GEN_ODD_LEN} gen_kind_t;

  // Predicts successors and checks returned words in order
  class perm_scoreboard;
    successor_t expected_results[$];
    int errors;
    int checked;
    int wraps;

    function new();
      errors  = 0;
      checked = 0;
      wraps   = 0;
    endfunction

    function successor_t next_arrangement(arrangement_t a);
      successor_t r;
      int n, p, s, lo, hi, i;
      bit found, s_found;
      logic [FIELD_W-1:0] t;
      r.elem  = a.elem;
      n       = (a.length > SLOTS) ? SLOTS : int'(a.length);
      found   = 0;
      s_found = 0;
      p       = 0;
      s       = 0;
      // rightmost ascent
      for (i = n - 1; i >= 1; i--)
        if (!found && r.elem[i-1] < r.elem[i]) begin
          p     = i - 1;
          found = 1;
        end
      if (found) begin
        // rightmost element above the pivot
        for (i = n - 1; i > p; i--)
          if (!s_found && r.elem[i] > r.elem[p]) begin
            s       = i;
            s_found = 1;
          end
        t         = r.elem[p];
        r.elem[p] = r.elem[s];
        r.elem[s] = t;
        lo        = p + 1;
      end else begin
        lo = 0;
      end
      // reverse the tail (whole valid range when wrapping)
      hi = n - 1;
      while (lo < hi) begin
        t          = r.elem[lo];
        r.elem[lo] = r.elem[hi];
        r.elem[hi] = t;
        lo++;
        hi--;
      end
      r.pivot   = found ? POS_W'(p) : '0;
      r.succ    = found ? POS_W'(s) : '0;
      r.wrapped = !found;
      return r;
    endfunction

    function void report(string what);
      errors++;
      $display("mismatch %0d: %s", errors, what);
    endfunction

    function void note(arrangement_t a);
      expected_results.push_back(next_arrangement(a));
    endfunction

    function void check(successor_t got);
      successor_t exp;
      int i;
      if (expected_results.size() == 0) begin
        report("result word with nothing outstanding");
        return;
      end
      exp = expected_results.pop_front();
      for (i = 0; i < SLOTS; i++)
        if (got.elem[i] !== exp.elem[i])
          report($sformatf("word %0d out_%0d: got %02h, want %02h",
                           checked, i, got.elem[i], exp.elem[i]));
      if (got.pivot !== exp.pivot)
        report($sformatf("word %0d pivot_pos: got %0d, want %0d",
                         checked, got.pivot, exp.pivot));
      if (got.succ !== exp.succ)
        report($sformatf("word %0d succ_pos: got %0d, want %0d",
                         checked, got.succ, exp.succ));
      if (got.wrapped !== exp.wrapped)
        report($sformatf("word %0d wrapped: got %b, want %b",
                         checked, got.wrapped, exp.wrapped));
      if (exp.wrapped) wraps++;
      checked++;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;

  perm_scoreboard sb = new();

  int cycles     = 0;
  int rx_mode    = 0;
  int rx_left    = 0;
  int burst_left = 0;
  int n_directed = 0;
  int n_random   = 0;
  int walk_steps = 0;

  next_lexicographic_permutation_top u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk = ~clk;

  // Word packing: length then elements from bit 0, pad bits zero
  function logic [S_DATA_W-1:0] pack_arrangement(arrangement_t a);
    logic [S_DATA_W-1:0] d;
    int i;
    d            = '0;
    d[LEN_W-1:0] = a.length;
    for (i = 0; i < SLOTS; i++)
      d[LEN_W + FIELD_W*i +: FIELD_W] = a.elem[i];
    return d;
  endfunction

  function arrangement_t unpack_arrangement(logic [S_DATA_W-1:0] d);
    arrangement_t a;
    int i;
    a.length = d[LEN_W-1:0];
    for (i = 0; i < SLOTS; i++)
      a.elem[i] = d[LEN_W + FIELD_W*i +: FIELD_W];
    return a;
  endfunction

  function successor_t unpack_successor(logic [M_DATA_W-1:0] d);
    successor_t r;
    int i;
    for (i = 0; i < SLOTS; i++)
      r.elem[i] = d[FIELD_W*i +: FIELD_W];
    r.pivot   = d[PIV_LSB +: POS_W];
    r.succ    = d[SUCC_LSB +: POS_W];
    r.wrapped = d[WRAP_BIT];
    return r;
  endfunction

  // bytes holds elem_7 in the top byte down to elem_0 in the bottom byte
  function arrangement_t arr(int len, logic [63:0] bytes);
    arrangement_t a;
    a.length = LEN_W'(len);
    a.elem   = bytes;
    return a;
  endfunction

  function arrangement_t make_random(gen_kind_t kind);
    arrangement_t a;
    int i, base, v, pos;
    logic [FIELD_W-1:0] t;
    for (i = 0; i < SLOTS; i++)
      a.elem[i] = FIELD_W'($urandom);
    case (kind)
      GEN_WIDE: begin
        a.length = LEN_W'($urandom_range(1, SLOTS));
      end
      GEN_DUP: begin
        a.length = LEN_W'($urandom_range(2, SLOTS));
        base     = $urandom_range(0, 253);
        for (i = 0; i < SLOTS; i++)
          a.elem[i] = FIELD_W'(base + $urandom_range(0, 2));
      end
      GEN_FALLING: begin
        // non-increasing run, sometimes with one ascent planted in it
        a.length = LEN_W'($urandom_range(2, SLOTS));
        v        = $urandom_range(128, 255);
        for (i = 0; i < a.length; i++) begin
          a.elem[i] = FIELD_W'(v);
          v         = v - $urandom_range(0, 30);
          if (v < 0) v = 0;
        end
        if ($urandom_range(0, 1) != 0) begin
          pos             = $urandom_range(0, a.length - 2);
          t               = a.elem[pos];
          a.elem[pos]     = a.elem[pos + 1];
          a.elem[pos + 1] = t;
        end
      end
      default: begin
        a.length = ($urandom_range(0, 3) == 0) ? '0 : LEN_W'($urandom_range(9, 15));
      end
    endcase
    return a;
  endfunction

  // Sender side
  task automatic send_item(arrangement_t a);
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pack_arrangement(a);
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic idle_sender(int n);
    repeat (n) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
    end
  endtask

  // Sender bursts of random length with random gaps, some gapless
  task automatic push(arrangement_t a);
    if (burst_left == 0) begin
      if ($urandom_range(0, 4) != 0)
        idle_sender($urandom_range(1, 8));
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    send_item(a);
  endtask

  // Hold off the sender until every outstanding result has come back
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0)
      @(posedge clk);
  endtask

  // Receiver stall pattern: phases of always ready, mostly ready,
  // mostly stalled, and one ready cycle in six
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(20, 80);
    end else begin
      rx_left = rx_left - 1;
    end
    case (rx_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
      2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= (cycles % 6 == 0);
    endcase
  end

  // Handshake monitor: inputs noted before results are checked
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note(unpack_arrangement(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready)
        sb.check(unpack_successor(m_axis_tdata));
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", sb.pending());
      $display("[next_lexicographic_permutation_top] ERROR");
      $finish;
    end
  end

  initial begin
    arrangement_t item, walk_cur;
    successor_t   walk_next;
    int           walk_left, i;
    gen_kind_t    kind;

    walk_left = 0;
    walk_cur  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: length extremes, element extremes, wrap, duplicates,
    // saturated length, pass-through of slots past the length
    push(arr(0,  64'hDEAD_BEEF_0123_4567));
    push(arr(1,  64'hA5A5_A5A5_A5A5_A5FF));
    push(arr(2,  64'h1111_1111_1111_FF00));
    push(arr(2,  64'h2222_2222_2222_00FF));
    push(arr(2,  64'h3333_3333_3333_7777));
    push(arr(8,  64'h0706_0504_0302_0100));
    push(arr(8,  64'hF8F9_FAFB_FCFD_FEFF));
    push(arr(8,  64'hFFFF_FFFF_FFFF_FFFF));
    push(arr(8,  64'h0000_0000_0000_0000));
    push(arr(8,  64'h0203_0405_0607_0801));
    push(arr(4,  64'h5555_5555_0202_0101));
    push(arr(4,  64'hAAAA_AAAA_0101_0202));
    push(arr(9,  64'h0706_0504_0302_0100));
    push(arr(15, 64'h0001_0203_0405_0607));
    push(arr(3,  64'hAA55_AA55_AA01_0203));
    push(arr(5,  64'hEEEE_EE02_0405_0301));
    push(arr(8,  64'h0000_0000_0000_807F));
    push(arr(7,  64'h9907_0605_0403_0102));
    push(arr(8,  64'h8080_8080_8080_807F));
    push(arr(6,  64'h0102_0101_0101_0101));
    push(arr(12, 64'hFF00_FF00_FF00_FF00));
    push(arr(8,  64'hFF00_FFFF_FFFF_FFFF));
    n_directed = 22;
    drain();

    // Random: permutation walks mixed with independent arrangements
    while (n_random < RANDOM_ITEMS) begin
      if (walk_left == 0 && $urandom_range(0, 9) < 4) begin
        walk_cur = make_random(GEN_WIDE);
        walk_cur.length = LEN_W'($urandom_range(2, 7));
        if ($urandom_range(0, 1) != 0)
          for (i = 0; i < walk_cur.length; i++)
            walk_cur.elem[i] = FIELD_W'($urandom_range(0, 3));
        walk_left = $urandom_range(8, 40);
      end
      if (walk_left > 0) begin
        item          = walk_cur;
        walk_next     = sb.next_arrangement(walk_cur);
        walk_cur.elem = walk_next.elem;
        walk_left--;
        walk_steps++;
      end else begin
        kind = gen_kind_t'($urandom_range(0, 3));
        item = make_random(kind);
      end
      push(item);
      n_random++;
      if (n_random == RANDOM_ITEMS / 2)
        drain();
    end

    drain();
    repeat (12) @(posedge clk);

    $display("sent %0d directed and %0d random arrangements (%0d on successor walks)",
             n_directed, n_random, walk_steps);
    $display("checked %0d results, %0d of them wrapped, %0d mismatches",
             sb.checked, sb.wraps, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("[next_lexicographic_permutation_top] OK");
    else
      $display("[next_lexicographic_permutation_top] ERROR");
    $finish;
  end

endmodule
